// ----- hw/rtl/decimal_field_formatter_defines.svh -----
// Assertion macros shared by the decimal field formatter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define DECIMAL_FIELD_FORMATTER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define DFF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define DFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/decfmt_pkg.sv -----
// Types and constants for the decimal field formatter.
// No dependencies; used by decfmt_dabble and decimal_field_formatter.
package decfmt_pkg;

   localparam int StoreDepth = 20;
   localparam int CountBits  = 5;

   localparam logic [6:0] AsciiZero  = 7'h30;
   localparam logic [6:0] AsciiSpace = 7'h20;
   localparam logic [3:0] AdjustMin  = 4'd5;
   localparam logic [3:0] AdjustAdd  = 4'd3;

   typedef logic [3:0] digit_type;
   typedef digit_type [StoreDepth-1:0] bcd_type;

   typedef struct packed {
      logic [63:0]          value;
      logic [CountBits-1:0] field_width;
   } req_type;

   typedef struct packed {
      logic [6:0]           char_code;
      logic [CountBits-1:0] char_index;
      logic                 last_char;
   } rsp_type;

endpackage

// ----- hw/rtl/decimal_field_formatter.sv -----
// Decimal field formatter top level: converts a binary value and emits ASCII beats.
// Depends on decfmt_pkg, decfmt_dabble and decimal_field_formatter_defines.svh.
//
//   channel   ports                     direction  handshake
//   request   start, busy, req_item     in         start && !busy
//   response  rsp_strobe, rsp_item      out        rsp_strobe, one cycle, no stall
//
// Before busy drops, one item goes through these steps: the bit-serial converter shifts
// one value bit per cycle, the digits are taken, leading zero digits are dropped one
// per cycle, the field is picked, then one character beat per cycle.
// The last beat shows in the first cycle with busy low; the receiver cannot stall.
// Reset is synchronous; it clears control state and drops any run in progress.
`include "decimal_field_formatter_defines.svh"

module decimal_field_formatter #(
   parameter int MAX_DIGITS = 20,
   parameter int VALUE_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  decfmt_pkg::req_type req_item,
   output logic                rsp_strobe,
   output decfmt_pkg::rsp_type rsp_item
);

   localparam int CB = decfmt_pkg::CountBits;

   typedef enum logic [1:0] {IDLE, CONVERT, NORMALIZE, EMIT} state_type;

   state_type            state_ff, state_in;
   decfmt_pkg::bcd_type  digits_ff, digits_in, conv_bcd;
   logic [CB-1:0]        width_ff, width_in;
   logic [CB-1:0]        ndig_ff, ndig_in;
   logic [CB-1:0]        pos_ff, pos_in;
   logic                 strobe_ff, strobe_in;
   decfmt_pkg::rsp_type  rsp_ff, rsp_in;
   logic                 conv_load, conv_done;
   logic [CB-1:0]        width_sat;
   decfmt_pkg::digit_type top_digit;

   assign conv_load = start && (state_ff == IDLE);
   assign width_sat = (req_item.field_width > CB'(MAX_DIGITS)) ?
                      CB'(MAX_DIGITS) : req_item.field_width;
   assign top_digit = digits_ff[decfmt_pkg::StoreDepth-1];

   decfmt_dabble #(.VALUE_BITS(VALUE_BITS)) u_dabble (
      .clock (clock),
      .reset (reset),
      .load  (conv_load),
      .value (req_item.value[VALUE_BITS-1:0]),
      .bcd   (conv_bcd),
      .done  (conv_done)
   );

   always_comb begin
      state_in  = state_ff;
      digits_in = digits_ff;
      width_in  = width_ff;
      ndig_in   = ndig_ff;
      pos_in    = pos_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               width_in = width_sat;
               state_in = CONVERT;
            end
         end
         CONVERT: begin
            if (conv_done) begin
               digits_in = conv_bcd;
               ndig_in   = CB'(decfmt_pkg::StoreDepth);
               state_in  = NORMALIZE;
            end
         end
         NORMALIZE: begin
            if (top_digit == '0 && ndig_ff > CB'(1)) begin
               digits_in = digits_ff << 4;
               ndig_in   = ndig_ff - 1'b1;
            end else if (width_ff == '0) begin
               state_in = IDLE;
            end else begin
               pos_in   = '0;
               state_in = EMIT;
            end
         end
         EMIT: begin
            strobe_in = 1'b1;
            rsp_in.char_code  = (pos_ff < ndig_ff) ?
                                decfmt_pkg::AsciiZero + {3'b000, top_digit} :
                                decfmt_pkg::AsciiSpace;
            rsp_in.char_index = pos_ff;
            rsp_in.last_char  = (pos_ff + 1'b1 == width_ff);
            digits_in = digits_ff << 4;
            pos_in    = pos_ff + 1'b1;
            if (pos_ff + 1'b1 == width_ff) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         strobe_ff <= 1'b0;
         width_ff  <= '0;
         ndig_ff   <= '0;
         pos_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         width_ff  <= width_in;
         ndig_ff   <= ndig_in;
         pos_ff    <= pos_in;
      end
      digits_ff <= digits_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   `DFF_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `DFF_ASSERT_SAME(a_index_in_field, clock, reset, rsp_strobe,
      rsp_item.char_index < width_ff)
   `DFF_ASSERT_NEXT(a_last_ends_run, clock, reset,
      rsp_strobe && rsp_item.last_char, !rsp_strobe)
   `DFF_ASSERT_NEXT(a_index_steps, clock, reset, rsp_strobe && !rsp_item.last_char,
      rsp_strobe && rsp_item.char_index == CB'($past(rsp_item.char_index) + 1'b1))

endmodule

// ----- hw/rtl/decfmt_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on decfmt_pkg.
module decfmt_dabble #(
   parameter int VALUE_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [VALUE_BITS-1:0]  value,
   output decfmt_pkg::bcd_type    bcd,
   output logic                   done
);

   localparam int CntBits = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   decfmt_pkg::bcd_type   bcd_ff, bcd_in, adj;
   logic [decfmt_pkg::StoreDepth*4-1:0] adj_bits;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   always_comb begin
      for (int i = 0; i < decfmt_pkg::StoreDepth; i++) begin
         adj[i] = (bcd_ff[i] >= decfmt_pkg::AdjustMin) ?
                  bcd_ff[i] + decfmt_pkg::AdjustAdd : bcd_ff[i];
      end
   end

   assign adj_bits = adj;

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (load) begin
         shift_in = value;
         bcd_in   = '0;
         cnt_in   = CntBits'(VALUE_BITS - 1);
         run_in   = 1'b1;
      end else if (run_ff) begin
         bcd_in   = {adj_bits[decfmt_pkg::StoreDepth*4-2:0], shift_ff[VALUE_BITS-1]};
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign bcd  = bcd_ff;
   assign done = done_ff;

endmodule

// ----- verif/tb_decimal_field_formatter.sv -----
// Self-checking bench for decimal_field_formatter: drives values and widths,
// predicts the ASCII beats in a scoreboard class and checks each one in order.
// Depends on decfmt_pkg and the decimal_field_formatter RTL.
module tb_decimal_field_formatter;

   localparam int MaxDigits    = 20;
   localparam int ValueBits    = 64;
   localparam int RandomItems  = 470;
   localparam int DrainCycles  = 130;
   localparam int CycleLimit   = 500000;
   localparam int IndexBits    = decfmt_pkg::CountBits;

   class decimal_text_board;
      decfmt_pkg::rsp_type pending_chars[$];
      bit      failed = 1'b0;

      function void note_value(decfmt_pkg::req_type item);
         logic [63:0]           rest;
         decfmt_pkg::digit_type digits[decfmt_pkg::StoreDepth];
         int                    count;
         int                    width;
         decfmt_pkg::rsp_type   beat;
         rest  = item.value & ({64{1'b1}} >> (64 - ValueBits));
         count = 0;
         do begin
            digits[count] = decfmt_pkg::digit_type'(rest % 64'd10);
            rest          = rest / 64'd10;
            count++;
         end while (rest != 0 && count < decfmt_pkg::StoreDepth);
         width = (item.field_width > MaxDigits) ? MaxDigits : int'(item.field_width);
         for (int pos = 0; pos < width; pos++) begin
            if (pos < count) begin
               beat.char_code = decfmt_pkg::AsciiZero + 7'(digits[count - 1 - pos]);
            end else begin
               beat.char_code = decfmt_pkg::AsciiSpace;
            end
            beat.char_index = IndexBits'(pos);
            beat.last_char  = (pos + 1 == width);
            pending_chars.push_back(beat);
         end
      endfunction

      function void check_char(decfmt_pkg::rsp_type actual);
         decfmt_pkg::rsp_type expected;
         if (pending_chars.size() == 0) begin
            $display("%0t unexpected beat: expected none actual %h/%0d/%b", $time,
                     actual.char_code, actual.char_index, actual.last_char);
            failed = 1'b1;
            return;
         end
         expected = pending_chars.pop_front();
         if (actual.char_code !== expected.char_code) begin
            $display("%0t char_code mismatch: expected %h actual %h", $time,
                     expected.char_code, actual.char_code);
            failed = 1'b1;
         end
         if (actual.char_index !== expected.char_index) begin
            $display("%0t char_index mismatch: expected %0d actual %0d", $time,
                     expected.char_index, actual.char_index);
            failed = 1'b1;
         end
         if (actual.last_char !== expected.last_char) begin
            $display("%0t last_char mismatch: expected %b actual %b", $time,
                     expected.last_char, actual.last_char);
            failed = 1'b1;
         end
      endfunction

      function int outstanding();
         return pending_chars.size();
      endfunction
   endclass

   logic                clock;
   logic                reset    = 1'b1;
   logic                start    = 1'b0;
   decfmt_pkg::req_type req_item = '0;
   logic                busy;
   logic                rsp_strobe;
   decfmt_pkg::rsp_type rsp_item;
   int                  cycle_count = 0;

   decimal_text_board board = new();

   decimal_field_formatter #(
      .MAX_DIGITS(MaxDigits),
      .VALUE_BITS(ValueBits)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            board.check_char(rsp_item);
         end
         if (start && !busy) begin
            board.note_value(req_item);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL decimal_field_formatter");
         $finish;
      end
   end

   function automatic logic [63:0] power_of_ten(int exponent);
      logic [63:0] result;
      result = 64'd1;
      for (int i = 0; i < exponent; i++) begin
         result = result * 64'd10;
      end
      return result;
   endfunction

   function automatic logic [63:0] random_value();
      logic [63:0] full;
      logic [63:0] result;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: result = full;
         1: result = full % power_of_ten($urandom_range(1, 19));
         2: result = power_of_ten($urandom_range(0, 19)) - 64'd1 + 64'($urandom_range(0, 2));
         3: result = 64'($urandom_range(0, 999));
         default: result = {64{1'b1}} - 64'($urandom_range(0, 1000));
      endcase
      return result;
   endfunction

   function automatic decfmt_pkg::req_type random_request();
      decfmt_pkg::req_type item;
      item.value = random_value();
      if ($urandom_range(0, 99) < 85) begin
         item.field_width = IndexBits'($urandom_range(0, MaxDigits));
      end else begin
         item.field_width = IndexBits'($urandom_range(MaxDigits + 1, 31));
      end
      return item;
   endfunction

   // Hold start until the request is taken.
   task automatic send_value(input decfmt_pkg::req_type item);
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender();
      int gap;
      gap = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 110);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      decfmt_pkg::req_type directed[$];
      int      sent;
      int      burst;
      directed.push_back('{value: 64'd0, field_width: 5'd0});
      directed.push_back('{value: 64'd0, field_width: 5'd1});
      directed.push_back('{value: 64'd0, field_width: 5'd5});
      directed.push_back('{value: 64'd0, field_width: 5'd20});
      directed.push_back('{value: {64{1'b1}}, field_width: 5'd20});
      directed.push_back('{value: {64{1'b1}}, field_width: 5'd31});
      directed.push_back('{value: {64{1'b1}}, field_width: 5'd19});
      directed.push_back('{value: {64{1'b1}}, field_width: 5'd1});
      directed.push_back('{value: {64{1'b1}}, field_width: 5'd0});
      directed.push_back('{value: 64'd9, field_width: 5'd1});
      directed.push_back('{value: 64'd10, field_width: 5'd1});
      directed.push_back('{value: 64'd10, field_width: 5'd2});
      directed.push_back('{value: 64'd99, field_width: 5'd4});
      directed.push_back('{value: 64'd100, field_width: 5'd3});
      directed.push_back('{value: 64'd12345, field_width: 5'd3});
      directed.push_back('{value: 64'd1, field_width: 5'd21});
      directed.push_back('{value: 64'd7, field_width: 5'd16});
      directed.push_back('{value: power_of_ten(19), field_width: 5'd20});
      directed.push_back('{value: power_of_ten(19) - 64'd1, field_width: 5'd25});
      directed.push_back('{value: power_of_ten(19) - 64'd1, field_width: 5'd18});
      directed.push_back('{value: 64'h8000_0000_0000_0000, field_width: 5'd20});
      directed.push_back('{value: 64'h5555_5555_5555_5555, field_width: 5'd10});
      directed.push_back('{value: 64'hAAAA_AAAA_AAAA_AAAA, field_width: 5'd8});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_value(directed[i]);
         if ($urandom_range(0, 1) == 0) begin
            pause_sender();
         end
      end

      sent = 0;
      while (sent < RandomItems) begin
         burst = $urandom_range(1, 8);
         for (int i = 0; i < burst && sent < RandomItems; i++) begin
            send_value(random_request());
            sent++;
         end
         pause_sender();
      end

      start <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (!board.failed) begin
         $display("PASS decimal_field_formatter");
      end else begin
         $display("FAIL decimal_field_formatter");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/decfmt_pkg.sv
hw/rtl/decfmt_dabble.sv
hw/rtl/decimal_field_formatter.sv
verif/tb_decimal_field_formatter.sv
